FILE: hw/rtl/rsfu_pkg.sv
package rsfu_pkg;

   localparam int ENTRIES_DEF = 8;
   localparam int UNITS = 4;
   localparam int ROB_DEPTH_DEF = 32;

   localparam logic [2:0] MODE_ISSUE = 3'd0;
   localparam logic [2:0] MODE_EXT_READY = 3'd1;
   localparam logic [2:0] MODE_REALLOC = 3'd2;
   localparam logic [2:0] MODE_TICK = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;

   localparam logic [1:0] KIND_ACK = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_IDLE = 2'd2;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_BAD_OP = 2'd2;

   localparam logic [4:0] OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_SUB = 5'd2, OP_BEQ = 5'd3,
      OP_BNE = 5'd4, OP_BLT = 5'd5, OP_BGE = 5'd6, OP_BLTU = 5'd7, OP_BGEU = 5'd8,
      OP_SLT = 5'd9, OP_SLTU = 5'd10, OP_SLTI = 5'd11, OP_SLTIU = 5'd12, OP_XOR = 5'd13,
      OP_XORI = 5'd14, OP_OR = 5'd15, OP_ORI = 5'd16, OP_AND = 5'd17, OP_ANDI = 5'd18,
      OP_SLL = 5'd19, OP_SLLI = 5'd20, OP_SRL = 5'd21, OP_SRLI = 5'd22, OP_SRA = 5'd23,
      OP_SRAI = 5'd24;

   localparam logic [4:0] SHAMT_MASK = 5'b11111;

   typedef struct packed {
      logic [2:0]         mode;
      logic [4:0]         op;
      logic signed [31:0] value1;
      logic signed [31:0] value2;
      logic               wait1;
      logic [4:0]         tag1;
      logic               wait2;
      logic [4:0]         tag2;
      logic [4:0]         dest_tag;
      logic [4:0]         ext_tag;
      logic signed [31:0] ext_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         status;
      logic [2:0]         slot;
      logic [4:0]         done_tag;
      logic signed [31:0] done_value;
      logic               last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic exec;       // apply request (non-tick)
      logic retire;     // tick: retire one unit
      logic [1:0] unit; // unit being retired
      logic tick_end;   // tick: dispatch, capture, advance units
      logic emit;       // load output register
      logic emit_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] mode;
      logic [UNITS-1:0] finished;
   } stat_type;

   function automatic logic [1:0] unit_of(input logic [4:0] op);
      if (op <= OP_SUB) return 2'd0;
      else if (op <= OP_SLTIU) return 2'd1;
      else if (op <= OP_ANDI) return 2'd2;
      else return 2'd3;
   endfunction

   function automatic logic [31:0] compute(input logic [31:0] a, input logic [31:0] b,
                                            input logic [4:0] op);
      logic [4:0] s;
      logic slt;
      s = b[4:0] & SHAMT_MASK;
      slt = $signed(a) < $signed(b);
      case (op)
         OP_ADD, OP_ADDI: return a + b;
         OP_SUB: return a - b;
         OP_BEQ: return {31'd0, a == b};
         OP_BNE: return {31'd0, a != b};
         OP_BLT, OP_SLT, OP_SLTI: return {31'd0, slt};
         OP_BGE: return {31'd0, !slt};
         OP_BLTU, OP_SLTU, OP_SLTIU: return {31'd0, a < b};
         OP_BGEU: return {31'd0, a >= b};
         OP_XOR, OP_XORI: return a ^ b;
         OP_OR, OP_ORI: return a | b;
         OP_AND, OP_ANDI: return a & b;
         OP_SLL, OP_SLLI: return a << s;
         OP_SRL, OP_SRLI: return a >> s;
         OP_SRA, OP_SRAI: return $unsigned($signed(a) >>> s);
         default: return 32'd0;
      endcase
   endfunction

endpackage

FILE: hw/rtl/rsfu_if.sv
interface rsfu_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rsfu_ctrl.sv
module rsfu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsfu_pkg::stat_type stat,
   output rsfu_pkg::cmd_type  cmd
);
   import rsfu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_RET  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] unit_ff, unit_in;
   logic valid_ff, valid_in;
   logic [UNITS-1:0] fin_ff, fin_in;
   logic any_ff, any_in;
   logic more;

   assign rsp_valid = valid_ff;
   assign req_ready = (state_ff == ST_IDLE) && !valid_ff;

   // any finished unit above the current one
   always_comb begin
      more = 1'b0;
      for (int u = 0; u < UNITS; u++)
         if (u > unit_ff && fin_ff[u]) more = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      unit_in = unit_ff;
      valid_in = valid_ff;
      fin_in = fin_ff;
      any_in = any_ff;
      cmd = '0;
      cmd.unit = unit_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.mode == MODE_TICK) begin
               fin_in = stat.finished;
               unit_in = 2'd0;
               any_in = 1'b0;
               state_in = ST_RET;
            end else begin
               cmd.exec = 1'b1;
               cmd.emit = 1'b1;
               cmd.emit_last = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RET: begin
            if (!valid_ff || rsp_ready) begin
               if (fin_ff[unit_ff]) begin
                  cmd.retire = 1'b1;
                  cmd.emit = 1'b1;
                  cmd.emit_last = !more;
                  valid_in = 1'b1;
                  any_in = 1'b1;
               end
               if (unit_ff == 2'd3) state_in = ST_OUT;
               else unit_in = unit_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.tick_end = 1'b1;
               if (!any_ff) begin
                  cmd.emit = 1'b1;
                  cmd.emit_last = 1'b1;
                  valid_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         unit_ff <= 2'd0;
         valid_ff <= 1'b0;
         fin_ff <= '0;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unit_ff <= unit_in;
         valid_ff <= valid_in;
         fin_ff <= fin_in;
         any_ff <= any_in;
      end
   end
endmodule

FILE: hw/rtl/rsfu_dp.sv
module rsfu_dp #(
   parameter int ENTRIES = rsfu_pkg::ENTRIES_DEF,
   parameter int ROB_DEPTH = rsfu_pkg::ROB_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  rsfu_pkg::req_type  req_data,
   input  rsfu_pkg::cmd_type  cmd,
   output rsfu_pkg::stat_type stat,
   output rsfu_pkg::rsp_type  rsp_data
);
   import rsfu_pkg::*;

   localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int TW = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;

   req_type req_ff;
   rsp_type rsp_ff, rsp_in;

   logic [ENTRIES-1:0] used_ff, disp_ff, rdy_ff;
   logic [ENTRIES-1:0] used_in, disp_in, rdy_in;
   logic [4:0]  op_ff [ENTRIES];
   logic [31:0] a_ff [ENTRIES];
   logic [31:0] b_ff [ENTRIES];
   logic        wa_ff [ENTRIES];
   logic        wb_ff [ENTRIES];
   logic [4:0]  ta_ff [ENTRIES];
   logic [4:0]  tb_ff [ENTRIES];
   logic [4:0]  dst_ff [ENTRIES];

   logic [UNITS-1:0] busy_ff, fin_ff, busy_in, fin_in;
   logic [31:0]   ans_ff [UNITS];
   logic [SW-1:0] uslot_ff [UNITS];

   logic [ROB_DEPTH-1:0] trdy_ff, trdy_in;
   logic [31:0] tval_ff [ROB_DEPTH];

   // retire path
   logic [SW-1:0] rs;
   logic [4:0] rd;
   assign rs = uslot_ff[cmd.unit];
   assign rd = dst_ff[rs];

   // free slot search
   logic found;
   logic [SW-1:0] free_idx;
   always_comb begin
      found = 1'b0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++)
         if (!found && !used_ff[i]) begin
            found = 1'b1;
            free_idx = SW'(i);
         end
   end

   // dispatch pick, per unit
   logic [UNITS-1:0] pick_ok;
   logic [SW-1:0] pick_idx [UNITS];
   always_comb begin
      for (int u = 0; u < UNITS; u++) begin
         pick_ok[u] = 1'b0;
         pick_idx[u] = '0;
      end
      for (int i = 0; i < ENTRIES; i++)
         if (used_ff[i] && !disp_ff[i] && rdy_ff[i])
            for (int u = 0; u < UNITS; u++)
               if (unit_of(op_ff[i]) == 2'(u) && !pick_ok[u]) begin
                  pick_ok[u] = 1'b1;
                  pick_idx[u] = SW'(i);
               end
   end

   logic bad_op;
   assign bad_op = req_ff.op > OP_SRAI;
   assign stat.mode = req_ff.mode;
   assign stat.finished = fin_ff;
   assign rsp_data = rsp_ff;

   logic ta_hit [ENTRIES];
   logic tb_hit [ENTRIES];
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         ta_hit[i] = wa_ff[i] && (32'(ta_ff[i]) < ROB_DEPTH) && trdy_ff[TW'(ta_ff[i])];
         tb_hit[i] = wb_ff[i] && (32'(tb_ff[i]) < ROB_DEPTH) && trdy_ff[TW'(tb_ff[i])];
      end
   end

   always_comb begin
      used_in = used_ff;
      disp_in = disp_ff;
      rdy_in = rdy_ff;
      busy_in = busy_ff;
      fin_in = fin_ff;
      trdy_in = trdy_ff;
      rsp_in = rsp_ff;
      if (cmd.exec) begin
         unique case (req_ff.mode)
            MODE_ISSUE:
               if (!bad_op && found) begin
                  used_in[free_idx] = 1'b1;
                  disp_in[free_idx] = 1'b0;
                  rdy_in[free_idx] = !req_ff.wait1 && !req_ff.wait2;
               end
            MODE_EXT_READY:
               if (32'(req_ff.ext_tag) < ROB_DEPTH) trdy_in[TW'(req_ff.ext_tag)] = 1'b1;
            MODE_REALLOC:
               if (32'(req_ff.ext_tag) < ROB_DEPTH) trdy_in[TW'(req_ff.ext_tag)] = 1'b0;
            MODE_CLEAR: begin
               used_in = '0;
               disp_in = '0;
               rdy_in = '0;
               busy_in = '0;
               fin_in = '0;
               trdy_in = '0;
            end
            default: ;
         endcase
      end
      if (cmd.retire) begin
         if (32'(rd) < ROB_DEPTH) trdy_in[TW'(rd)] = 1'b1;
         used_in[rs] = 1'b0;
         busy_in[cmd.unit] = 1'b0;
         fin_in[cmd.unit] = 1'b0;
      end
      if (cmd.tick_end) begin
         // busy units advance; retire already cleared finished ones
         for (int u = 0; u < UNITS; u++)
            if (busy_ff[u]) begin
               busy_in[u] = 1'b0;
               fin_in[u] = 1'b1;
            end
         for (int u = 0; u < UNITS; u++)
            if (pick_ok[u] && !busy_ff[u]) begin
               busy_in[u] = 1'b1;
               fin_in[u] = 1'b0;
               disp_in[pick_idx[u]] = 1'b1;
            end
         for (int i = 0; i < ENTRIES; i++)
            if (used_ff[i] && !rdy_ff[i])
               if ((!wa_ff[i] || ta_hit[i]) && (!wb_ff[i] || tb_hit[i])) rdy_in[i] = 1'b1;
      end
      if (cmd.emit) begin
         rsp_in = '0;
         rsp_in.last = cmd.emit_last;
         if (cmd.retire) begin
            rsp_in.kind = KIND_DONE;
            rsp_in.slot = 3'(rs);
            rsp_in.done_tag = rd;
            rsp_in.done_value = ans_ff[cmd.unit];
         end else if (cmd.tick_end) begin
            rsp_in.kind = KIND_IDLE;
         end else if (req_ff.mode == MODE_ISSUE) begin
            if (bad_op) rsp_in.status = STAT_BAD_OP;
            else if (!found) rsp_in.status = STAT_FULL;
            else rsp_in.slot = 3'(free_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         disp_ff <= '0;
         rdy_ff <= '0;
         busy_ff <= '0;
         fin_ff <= '0;
         trdy_ff <= '0;
      end else begin
         used_ff <= used_in;
         disp_ff <= disp_in;
         rdy_ff <= rdy_in;
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         trdy_ff <= trdy_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load) req_ff <= req_data;
      if (cmd.exec && req_ff.mode == MODE_ISSUE && !bad_op && found) begin
         op_ff[free_idx] <= req_ff.op;
         a_ff[free_idx] <= req_ff.value1;
         b_ff[free_idx] <= req_ff.value2;
         wa_ff[free_idx] <= req_ff.wait1;
         wb_ff[free_idx] <= req_ff.wait2;
         ta_ff[free_idx] <= req_ff.tag1;
         tb_ff[free_idx] <= req_ff.tag2;
         dst_ff[free_idx] <= req_ff.dest_tag;
      end
      if (cmd.exec && req_ff.mode == MODE_EXT_READY && 32'(req_ff.ext_tag) < ROB_DEPTH)
         tval_ff[TW'(req_ff.ext_tag)] <= req_ff.ext_value;
      if (cmd.retire && 32'(rd) < ROB_DEPTH) tval_ff[TW'(rd)] <= ans_ff[cmd.unit];
      if (cmd.tick_end) begin
         for (int u = 0; u < UNITS; u++)
            if (pick_ok[u] && !busy_ff[u]) begin
               ans_ff[u] <= compute(a_ff[pick_idx[u]], b_ff[pick_idx[u]], op_ff[pick_idx[u]]);
               uslot_ff[u] <= pick_idx[u];
            end
         for (int i = 0; i < ENTRIES; i++)
            if (used_ff[i] && !rdy_ff[i]) begin
               if (ta_hit[i]) begin
                  wa_ff[i] <= 1'b0;
                  a_ff[i] <= tval_ff[TW'(ta_ff[i])];
               end
               if (tb_hit[i]) begin
                  wb_ff[i] <= 1'b0;
                  b_ff[i] <= tval_ff[TW'(tb_ff[i])];
               end
            end
      end
   end
endmodule

FILE: hw/rtl/reservation_station_four_units.sv
// non-tick modes: request captured, applied in ST_EXEC, response registered in rsp_ff
// tick: ST_RET walks the four units, one response per retiring unit (idle if none)
// throughput: one request at a time; next request taken once the last response is out
// the retire sequencer walking the four units sets the tick length
// reset: synchronous, active high; clears slot, unit and tag-ready flags
module reservation_station_four_units #(
   parameter int ENTRIES = rsfu_pkg::ENTRIES_DEF,
   parameter int ROB_DEPTH = rsfu_pkg::ROB_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   rsfu_if.sink   req,
   rsfu_if.source rsp
);
   import rsfu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rsfu_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   rsfu_dp #(.ENTRIES(ENTRIES), .ROB_DEPTH(ROB_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .req_data(req.data), .cmd(cmd), .stat(stat), .rsp_data(rsp.data)
   );

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.retire && cmd.tick_end)) else $error("retire and tick end together");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |-> !rsp.valid) else $error("request taken with response pending");
   a_retire_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.retire |=> rsp.valid && rsp.data.kind == KIND_DONE) else $error("retire lost");
endmodule
